FILE: rtl/rcpam_pkg.sv
// Shared types, register codes and constants for the RC pulse to actuator mapper.
// No dependencies; every other file in rtl/ except rcpam_fifo uses this package.
package rcpam_pkg;

  localparam int TICK_W   = 24;
  localparam int REG_W    = 16;
  localparam int IDX_W    = 3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_VALID_MIN    = 3'd0;
  localparam logic [IDX_W-1:0] REG_VALID_MAX    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DEAD_LOW     = 3'd2;
  localparam logic [IDX_W-1:0] REG_DEAD_HIGH    = 3'd3;
  localparam logic [IDX_W-1:0] REG_FULL_FORWARD = 3'd4;
  localparam logic [IDX_W-1:0] REG_FULL_REVERSE = 3'd5;
  localparam logic [IDX_W-1:0] REG_CENTER       = 3'd6;

  localparam logic [REG_W-1:0] RST_VALID_MIN    = 16'd12800;
  localparam logic [REG_W-1:0] RST_VALID_MAX    = 16'd35200;
  localparam logic [REG_W-1:0] RST_DEAD_LOW     = 16'd23200;
  localparam logic [REG_W-1:0] RST_DEAD_HIGH    = 16'd24800;
  localparam logic [REG_W-1:0] RST_FULL_FORWARD = 16'd16000;
  localparam logic [REG_W-1:0] RST_FULL_REVERSE = 16'd32000;
  localparam logic [REG_W-1:0] RST_CENTER       = 16'd24000;

  // Actuator values after reset; the DAC idle code is also the run-time idle code
  localparam logic [15:0] DAC_IDLE        = 16'd7745;
  localparam logic [14:0] RST_BRAKE_FRONT = 15'd25458;
  localparam logic [15:0] RST_BRAKE_REAR  = 16'd5193;
  localparam logic [12:0] RST_STEER       = 13'd4000;

  // Command operations handed from front end to back end
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_THR_IDLE  = 3'd0;
  localparam logic [OP_W-1:0] OP_THR_DAC   = 3'd1;
  localparam logic [OP_W-1:0] OP_THR_BRAKE = 3'd2;
  localparam logic [OP_W-1:0] OP_STR_IDLE  = 3'd3;
  localparam logic [OP_W-1:0] OP_STR_RUN   = 3'd4;

  // Back end jobs: one division each
  localparam int JOB_W = 3;
  localparam logic [JOB_W-1:0] J_DAC = 3'd0;
  localparam logic [JOB_W-1:0] J_BF  = 3'd1;
  localparam logic [JOB_W-1:0] J_BR  = 3'd2;
  localparam logic [JOB_W-1:0] J_SA  = 3'd3;
  localparam logic [JOB_W-1:0] J_SB  = 3'd4;

  localparam int CMD_W  = 17;             // signed n and d
  localparam int TERM_W = 27;             // signed scaled terms
  localparam int DEN_W  = 26;             // divisor
  localparam int QUOT_W = 17;             // quotient kept before saturation
  localparam int NUM_W  = DEN_W + QUOT_W; // dividend

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  typedef struct packed {
    logic              channel;
    logic              level;
    logic [TICK_W-1:0] timer_value;
  } in_t;

  typedef struct packed {
    logic              channel_done;
    logic [TICK_W-1:0] pulse_ticks;
    logic              in_range;
    logic [15:0]       dac_code;
    logic [14:0]       brake_front_compare;
    logic [15:0]       brake_rear_compare;
    logic [12:0]       steer_a_compare;
    logic [12:0]       steer_b_compare;
  } res_t;

  typedef struct packed {
    logic [REG_W-1:0] valid_min;
    logic [REG_W-1:0] valid_max;
    logic [REG_W-1:0] dead_low;
    logic [REG_W-1:0] dead_high;
    logic [REG_W-1:0] full_forward;
    logic [REG_W-1:0] full_reverse;
    logic [REG_W-1:0] center;
  } cfg_t;

  typedef struct packed {
    logic                    ch;
    logic [TICK_W-1:0]       pulse_ticks;
    logic                    in_range;
    logic [OP_W-1:0]         op;
    logic signed [CMD_W-1:0] n;
    logic signed [CMD_W-1:0] d;
  } cmd_t;

  // x = ka*d +/- kb*n, den = kd*d
  typedef struct packed {
    logic [9:0] ka;
    logic [8:0] kb;
    logic [9:0] kd;
    logic       sub;
  } coef_t;

  function automatic coef_t job_coef(input logic [JOB_W-1:0] job);
    coef_t c;
    c = '0;
    unique case (job)
      J_DAC: c = '{ka: 10'd39,  kb: 9'd21,  kd: 10'd330,  sub: 1'b0};
      J_BF:  c = '{ka: 10'd843, kb: 9'd308, kd: 10'd1000, sub: 1'b1};
      J_BR:  c = '{ka: 10'd155, kb: 9'd338, kd: 10'd1000, sub: 1'b0};
      J_SA:  c = '{ka: 10'd5,   kb: 9'd2,   kd: 10'd10,   sub: 1'b1};
      J_SB:  c = '{ka: 10'd5,   kb: 9'd2,   kd: 10'd10,   sub: 1'b0};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/rcpam_fifo.sv
// Small flip-flop queue used between front and back end and on the result side.
// Depends on nothing but its parameters.
module rcpam_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !empty)
    else $error("queue empty after an accepted push");

endmodule

FILE: rtl/rcpam_front.sv
// Front end: takes edge events, keeps rise timestamps, measures pulse width and
// classifies it into a back-end command. Uses rcpam_pkg.
module rcpam_front #(
  parameter int TIMER_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  rcpam_pkg::in_t   item,
  input  rcpam_pkg::cfg_t  cfg,
  output logic             q_push,
  output rcpam_pkg::cmd_t  q_data,
  input  logic             q_full
);
  import rcpam_pkg::*;

  logic [TICK_W-1:0]     rise_time [2];
  logic                  s1_valid;
  logic                  s1_ch;
  logic [TIMER_BITS-1:0] s1_w;
  logic                  accept;
  logic [31:0]           rise32;
  logic [31:0]           now32;
  logic [31:0]           w32;
  logic [15:0]           w16;
  logic                  in_range;
  logic                  below;
  logic                  above;
  logic signed [CMD_W-1:0] n_fwd, d_fwd, n_rev, d_rev, n_ctr, d_ctr;

  assign full   = s1_valid && q_full;
  assign accept = push && !full;
  assign q_push = s1_valid && !q_full;

  // Width wraps at the timer size
  assign rise32 = 32'(rise_time[item.channel]);
  assign now32  = 32'(item.timer_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_time[0] <= '0;
      rise_time[1] <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept && item.level) begin
        rise_time[item.channel] <= 24'(now32[TIMER_BITS-1:0]);
      end
      if (accept && !item.level) begin
        s1_valid <= 1'b1;
      end else if (q_push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !item.level) begin
      s1_ch <= item.channel;
      s1_w  <= rise32[TIMER_BITS-1:0] - now32[TIMER_BITS-1:0];
    end
  end

  always_comb begin
    w32      = 32'(s1_w);
    w16      = w32[15:0];
    in_range = (w32 > 32'(cfg.valid_min)) && (w32 < 32'(cfg.valid_max));
    below    = w16 < cfg.dead_low;
    above    = w16 > cfg.dead_high;
    n_fwd    = $signed({1'b0, cfg.dead_low})     - $signed({1'b0, w16});
    d_fwd    = $signed({1'b0, cfg.dead_low})     - $signed({1'b0, cfg.full_forward});
    n_rev    = $signed({1'b0, w16})              - $signed({1'b0, cfg.dead_high});
    d_rev    = $signed({1'b0, cfg.full_reverse}) - $signed({1'b0, cfg.dead_high});
    n_ctr    = $signed({1'b0, w16})              - $signed({1'b0, cfg.center});
    d_ctr    = $signed({1'b0, cfg.full_reverse}) - $signed({1'b0, cfg.center});

    q_data.ch          = s1_ch;
    q_data.pulse_ticks = w32[TICK_W-1:0];
    q_data.in_range    = in_range;
    q_data.n           = '0;
    q_data.d           = '0;
    if (!s1_ch) begin
      q_data.op = OP_THR_IDLE;
      // below-deadband test wins when the deadband edges are swapped
      if (in_range && below) begin
        if (d_fwd > 17'sd0) begin
          q_data.op = OP_THR_DAC;
          q_data.n  = n_fwd;
          q_data.d  = d_fwd;
        end
      end else if (in_range && above) begin
        if (d_rev > 17'sd0) begin
          q_data.op = OP_THR_BRAKE;
          q_data.n  = n_rev;
          q_data.d  = d_rev;
        end
      end
    end else begin
      q_data.op = OP_STR_IDLE;
      if (in_range && (below || above) && (d_ctr != 17'sd0)) begin
        q_data.op = OP_STR_RUN;
        q_data.n  = n_ctr;
        q_data.d  = d_ctr;
      end
    end
  end

endmodule

FILE: rtl/rcpam_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to all ones
// when it would not fit. Uses rcpam_pkg for widths.
module rcpam_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rcpam_pkg::NUM_W-1:0]  num,
  input  logic [rcpam_pkg::DEN_W-1:0]  den,
  output logic                         done,
  output logic [rcpam_pkg::QUOT_W-1:0] quot
);
  import rcpam_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DEN_W-1:0]  rem;
  logic [QUOT_W-1:0] nlow;
  logic [NUM_W-1:0]  den_shift;
  logic [DEN_W:0]    trial;
  logic              fits;
  logic              overflow;

  assign den_shift = {den, {QUOT_W{1'b0}}};
  assign overflow  = num >= den_shift;
  assign trial     = {rem, nlow[QUOT_W-1]};
  assign fits      = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (overflow) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // high part is already below the divisor when there is no overflow
      rem  <= num[NUM_W-1:QUOT_W];
      nlow <= num[QUOT_W-1:0];
      cnt  <= CNT_W'(QUOT_W);
      quot <= overflow ? '1 : '0;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      nlow <= {nlow[QUOT_W-2:0], 1'b0};
      quot <= {quot[QUOT_W-2:0], fits};
      cnt  <= cnt - CNT_W'(1);
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

  a_finishes: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == CNT_W'(1) && !start) |=> done)
    else $error("divider missed its last step");

endmodule

FILE: rtl/rcpam_back.sv
// Back end: runs queued commands through a scale / multiply / divide / clamp
// sequence and keeps the held actuator values. Uses rcpam_pkg and rcpam_div.
module rcpam_back #(
  parameter int STEER_PERIOD       = 8000,
  parameter int BRAKE_FRONT_PERIOD = 30200,
  parameter int BRAKE_REAR_PERIOD  = 33506
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  output logic            q_pop,
  input  rcpam_pkg::cmd_t cmd,
  output logic            res_push,
  output rcpam_pkg::res_t res_data,
  input  logic            res_full
);
  import rcpam_pkg::*;

  localparam logic [15:0] SP       = 16'(STEER_PERIOD);
  localparam logic [15:0] SP_HALF  = 16'(STEER_PERIOD * 5 / 10);
  localparam logic [15:0] BF_PER   = 16'(BRAKE_FRONT_PERIOD);
  localparam logic [15:0] BF_LO    = 16'(BRAKE_FRONT_PERIOD * 535 / 1000);
  localparam logic [15:0] BF_HI    = 16'(BRAKE_FRONT_PERIOD * 843 / 1000);
  localparam logic [15:0] BR_PER   = 16'(BRAKE_REAR_PERIOD);
  localparam logic [15:0] BR_LO    = 16'(BRAKE_REAR_PERIOD * 155 / 1000);
  localparam logic [15:0] BR_HI    = 16'(BRAKE_REAR_PERIOD * 493 / 1000);
  localparam logic [15:0] DAC_FULL = 16'hFFFF;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TERM  = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DGO   = 3'd4;
  localparam logic [2:0] ST_DWAIT = 3'd5;
  localparam logic [2:0] ST_CLAMP = 3'd6;
  localparam logic [2:0] ST_PUSH  = 3'd7;

  logic [2:0]               state;
  cmd_t                     cur;
  logic [JOB_W-1:0]         job;
  logic signed [CMD_W-1:0]  dpos;
  logic signed [CMD_W-1:0]  npos;
  logic signed [TERM_W-1:0] ta, tb, x;
  logic [DEN_W-1:0]         den;
  logic [NUM_W-1:0]         num;
  logic                     neg;

  logic [15:0] held_dac;
  logic [14:0] held_bf;
  logic [15:0] held_br;
  logic [12:0] held_sa;
  logic [12:0] held_sb;

  coef_t                    coef;
  logic [15:0]              mulp, lo, hi, clamped;
  logic signed [TERM_W-1:0] ka_s, kb_s, kd_s, d_s, n_s, den_prod;
  logic [NUM_W-1:0]         p_ext, x_ext;
  logic                     div_start, div_done;
  logic [QUOT_W-1:0]        div_quot;

  rcpam_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign res_push  = (state == ST_PUSH) && !res_full;
  assign div_start = (state == ST_DGO);

  always_comb begin
    coef = job_coef(job);
    unique case (job) inside
      J_DAC:      begin mulp = DAC_FULL; lo = '0;    hi = DAC_FULL; end
      J_BF:       begin mulp = BF_PER;   lo = BF_LO; hi = BF_HI;    end
      J_BR:       begin mulp = BR_PER;   lo = BR_LO; hi = BR_HI;    end
      J_SA, J_SB: begin mulp = SP;       lo = '0;    hi = SP;       end
      default:    begin mulp = '0;       lo = '0;    hi = '0;       end
    endcase
    ka_s     = TERM_W'(coef.ka);
    kb_s     = TERM_W'(coef.kb);
    kd_s     = TERM_W'(coef.kd);
    d_s      = TERM_W'(dpos);
    n_s      = TERM_W'(npos);
    den_prod = kd_s * d_s;
    p_ext    = NUM_W'(mulp);
    x_ext    = NUM_W'(x[DEN_W-1:0]);
    // negative scaled value floors below every lower bound
    if (neg) begin
      clamped = lo;
    end else if (div_quot < {1'b0, lo}) begin
      clamped = lo;
    end else if (div_quot > {1'b0, hi}) begin
      clamped = hi;
    end else begin
      clamped = div_quot[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      held_dac <= DAC_IDLE;
      held_bf  <= RST_BRAKE_FRONT;
      held_br  <= RST_BRAKE_REAR;
      held_sa  <= RST_STEER;
      held_sb  <= RST_STEER;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (!cmd.ch) begin
              held_dac <= DAC_IDLE;
              held_bf  <= BF_HI[14:0];
              held_br  <= BR_LO;
            end else begin
              held_sa <= SP_HALF[12:0];
              held_sb <= SP_HALF[12:0];
            end
            case (cmd.op)
              OP_THR_DAC:   begin job <= J_DAC; state <= ST_TERM; end
              OP_THR_BRAKE: begin job <= J_BF;  state <= ST_TERM; end
              OP_STR_RUN:   begin job <= J_SA;  state <= ST_TERM; end
              default:      state <= ST_PUSH;
            endcase
          end
        end
        ST_TERM:  state <= ST_SUM;
        ST_SUM:   state <= ST_MUL;
        ST_MUL:   state <= ST_DGO;
        ST_DGO:   state <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          case (job)
            J_DAC:   held_dac <= clamped;
            J_BF:    held_bf  <= clamped[14:0];
            J_BR:    held_br  <= clamped;
            J_SA:    held_sa  <= clamped[12:0];
            default: held_sb  <= clamped[12:0];
          endcase
          if (job == J_BF) begin
            job   <= J_BR;
            state <= ST_TERM;
          end else if (job == J_SA) begin
            job   <= J_SB;
            state <= ST_TERM;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!res_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= cmd;
      // fold the divisor sign into the numerator so d stays positive
      dpos <= cmd.d[CMD_W-1] ? -cmd.d : cmd.d;
      npos <= cmd.d[CMD_W-1] ? -cmd.n : cmd.n;
    end
    if (state == ST_TERM) begin
      ta <= ka_s * d_s;
      tb <= kb_s * n_s;
    end
    if (state == ST_SUM) begin
      x   <= coef.sub ? ta - tb : ta + tb;
      den <= den_prod[DEN_W-1:0];
    end
    if (state == ST_MUL) begin
      num <= p_ext * x_ext;
      neg <= x[TERM_W-1];
    end
  end

  always_comb begin
    res_data.channel_done        = cur.ch;
    res_data.pulse_ticks         = cur.pulse_ticks;
    res_data.in_range            = cur.in_range;
    res_data.dac_code            = held_dac;
    res_data.brake_front_compare = held_bf;
    res_data.brake_rear_compare  = held_br;
    res_data.steer_a_compare     = held_sa;
    res_data.steer_b_compare     = held_sb;
  end

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DWAIT))
    else $error("divider result arrived outside the wait state");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_TERM || state == ST_PUSH))
    else $error("command popped without starting work");

endmodule

FILE: rtl/rc_pulse_to_actuator_mapper_unit.sv
// Top level of the RC pulse to actuator mapper: configuration registers, front
// end, command queue, back end and result queue. Uses rcpam_pkg and all rtl/ modules.
//
// Usage:
//   Input channel: an edge event (channel, level, timer_value) is taken on a
//   clock edge with push high and full low. Rising edges only store the
//   timestamp and produce no result. Falling edges produce exactly one result.
//   Result channel: while empty is low the oldest result is on result; it is
//   taken on a clock edge with pop high.
//   Configuration: cfg_we writes cfg_data to register cfg_index;
//   indexes past the last register are ignored. Write only while idle.
// Operation: a falling edge is registered in the front end, then the back end
//   runs one division per job through a shared 17-step divider; a quotient that
//   saturates up front skips the steps. Idle, out-of-range and deadband results
//   need no division, DAC results one job, brake and steering results two jobs.
//   The back end takes a new command only after the result of the last one is
//   pushed; rising edges only take an input slot. That sequencer sets the
//   sustained rate.
// Reset (synchronous, active high) loads register defaults, clears both
//   timestamps and the queues, and sets the held actuator values to idle.
// A stalled receiver fills the result queue, then the back end and the command
//   queue; full rises only when the front end can no longer hand off.
module rc_pulse_to_actuator_mapper_unit #(
  parameter int TIMER_BITS         = 24,
  parameter int STEER_PERIOD       = 8000,
  parameter int BRAKE_FRONT_PERIOD = 30200,
  parameter int BRAKE_REAR_PERIOD  = 33506
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  rcpam_pkg::in_t                item,
  output logic                          empty,
  input  logic                          pop,
  output rcpam_pkg::res_t               result,
  input  logic                          cfg_we,
  input  logic [rcpam_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rcpam_pkg::REG_W-1:0]   cfg_data
);
  import rcpam_pkg::*;

  cfg_t               cfg;
  logic               cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t               cmd_in, cmd_head;
  logic [$bits(cmd_t)-1:0] cmd_rdata;
  logic               res_push, res_full;
  res_t               res_in;
  logic [$bits(res_t)-1:0] res_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.valid_min    <= RST_VALID_MIN;
      cfg.valid_max    <= RST_VALID_MAX;
      cfg.dead_low     <= RST_DEAD_LOW;
      cfg.dead_high    <= RST_DEAD_HIGH;
      cfg.full_forward <= RST_FULL_FORWARD;
      cfg.full_reverse <= RST_FULL_REVERSE;
      cfg.center       <= RST_CENTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VALID_MIN:    cfg.valid_min    <= cfg_data;
        REG_VALID_MAX:    cfg.valid_max    <= cfg_data;
        REG_DEAD_LOW:     cfg.dead_low     <= cfg_data;
        REG_DEAD_HIGH:    cfg.dead_high    <= cfg_data;
        REG_FULL_FORWARD: cfg.full_forward <= cfg_data;
        REG_FULL_REVERSE: cfg.full_reverse <= cfg_data;
        REG_CENTER:       cfg.center       <= cfg_data;
        default:          ;
      endcase
    end
  end

  rcpam_front #(
    .TIMER_BITS (TIMER_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .cfg    (cfg),
    .q_push (cmd_push),
    .q_data (cmd_in),
    .q_full (cmd_full)
  );

  rcpam_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_rdata);

  rcpam_back #(
    .STEER_PERIOD       (STEER_PERIOD),
    .BRAKE_FRONT_PERIOD (BRAKE_FRONT_PERIOD),
    .BRAKE_REAR_PERIOD  (BRAKE_REAR_PERIOD)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (cmd_empty),
    .q_pop    (cmd_pop),
    .cmd      (cmd_head),
    .res_push (res_push),
    .res_data (res_in),
    .res_full (res_full)
  );

  rcpam_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign result = res_t'(res_rdata);

endmodule

FILE: bench/rc_pulse_to_actuator_mapper_checker.sv
// Scoreboard for the RC pulse to actuator mapper: watches the edge, result and
// register ports, predicts each measured pulse and compares it field by field.
// Depends on rcpam_pkg for the payload structs and the register codes.
module rc_pulse_to_actuator_mapper_checker #(
  parameter int STEER_PERIOD       = 8000,
  parameter int BRAKE_FRONT_PERIOD = 30200,
  parameter int BRAKE_REAR_PERIOD  = 33506
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  rcpam_pkg::in_t              item,
  input  logic                        empty,
  input  logic                        pop,
  input  rcpam_pkg::res_t             result,
  input  logic                        cfg_we,
  input  logic [rcpam_pkg::IDX_W-1:0] cfg_index,
  input  logic [rcpam_pkg::REG_W-1:0] cfg_data,
  output int                          mismatches,
  output int                          outstanding,
  output int                          checked
);
  import rcpam_pkg::*;

  localparam longint SP  = STEER_PERIOD;
  localparam longint BFP = BRAKE_FRONT_PERIOD;
  localparam longint BRP = BRAKE_REAR_PERIOD;

  cfg_t              regs;
  logic [TICK_W-1:0] stamp [2];
  logic [15:0]       dac_hold;
  logic [14:0]       front_hold;
  logic [15:0]       rear_hold;
  logic [12:0]       steer_a_hold;
  logic [12:0]       steer_b_hold;
  res_t              pending_results [$];
  int                fail_count = 0;
  int                done_count = 0;

  function automatic longint floor_quot(input longint num, input longint den);
    longint q;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    q = num / den;
    if (num % den != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [15:0] dac_level(input longint n, input longint d);
    return 16'(clip(floor_quot(65535 * (39 * d + 21 * n), 330 * d), 0, 65535));
  endfunction

  function automatic void set_brakes(input longint n, input longint d);
    longint f;
    longint r;
    f = floor_quot(BFP * (843 * d - 308 * n), 1000 * d);
    r = floor_quot(BRP * (155 * d + 338 * n), 1000 * d);
    front_hold = 15'(clip(f, BFP * 535 / 1000, BFP * 843 / 1000));
    rear_hold  = 16'(clip(r, BRP * 155 / 1000, BRP * 493 / 1000));
  endfunction

  function automatic void set_steer(input longint n, input longint d);
    steer_a_hold = 13'(clip(floor_quot(SP * (5 * d - 2 * n), 10 * d), 0, SP));
    steer_b_hold = 13'(clip(floor_quot(SP * (5 * d + 2 * n), 10 * d), 0, SP));
  endfunction

  // Rising edges only record the timestamp; falling edges yield one result.
  function automatic void decode_edge(input in_t ev);
    logic [TICK_W-1:0] width;
    longint w, vmin, vmax, dl, dh, ff, fr, ce;
    bit ok;
    res_t r;
    if (ev.level) begin
      stamp[ev.channel] = ev.timer_value;
      return;
    end
    width = stamp[ev.channel] - ev.timer_value;
    w    = width;
    vmin = regs.valid_min;
    vmax = regs.valid_max;
    dl   = regs.dead_low;
    dh   = regs.dead_high;
    ff   = regs.full_forward;
    fr   = regs.full_reverse;
    ce   = regs.center;
    ok   = (w > vmin) && (w < vmax);
    if (ev.channel == 1'b0) begin
      dac_hold = dac_level(0, 1);
      set_brakes(0, 1);
      // lower deadband test wins when the edges are misordered
      if (ok && w < dl) begin
        if (dl - ff > 0) dac_hold = dac_level(dl - w, dl - ff);
      end else if (ok && w > dh) begin
        if (fr - dh > 0) set_brakes(w - dh, fr - dh);
      end
    end else begin
      if (ok && (w < dl || w > dh) && fr - ce != 0) set_steer(w - ce, fr - ce);
      else set_steer(0, 1);
    end
    r.channel_done        = ev.channel;
    r.pulse_ticks         = width;
    r.in_range            = ok;
    r.dac_code            = dac_hold;
    r.brake_front_compare = front_hold;
    r.brake_rear_compare  = rear_hold;
    r.steer_a_compare     = steer_a_hold;
    r.steer_b_compare     = steer_b_hold;
    pending_results.push_back(r);
  endfunction

  function automatic string field_diffs(input res_t got, input res_t want);
    string s;
    s = "";
    if (got.channel_done !== want.channel_done)
      s = {s, $sformatf(" channel_done exp %0d got %0d", want.channel_done, got.channel_done)};
    if (got.pulse_ticks !== want.pulse_ticks)
      s = {s, $sformatf(" pulse_ticks exp %0d got %0d", want.pulse_ticks, got.pulse_ticks)};
    if (got.in_range !== want.in_range)
      s = {s, $sformatf(" in_range exp %0d got %0d", want.in_range, got.in_range)};
    if (got.dac_code !== want.dac_code)
      s = {s, $sformatf(" dac_code exp %0d got %0d", want.dac_code, got.dac_code)};
    if (got.brake_front_compare !== want.brake_front_compare)
      s = {s, $sformatf(" brake_front exp %0d got %0d",
                        want.brake_front_compare, got.brake_front_compare)};
    if (got.brake_rear_compare !== want.brake_rear_compare)
      s = {s, $sformatf(" brake_rear exp %0d got %0d",
                        want.brake_rear_compare, got.brake_rear_compare)};
    if (got.steer_a_compare !== want.steer_a_compare)
      s = {s, $sformatf(" steer_a exp %0d got %0d", want.steer_a_compare, got.steer_a_compare)};
    if (got.steer_b_compare !== want.steer_b_compare)
      s = {s, $sformatf(" steer_b exp %0d got %0d", want.steer_b_compare, got.steer_b_compare)};
    return s;
  endfunction

  always @(posedge clk) begin : watch
    res_t  want;
    string diffs;
    if (rst) begin
      regs = cfg_t'{valid_min: RST_VALID_MIN, valid_max: RST_VALID_MAX,
                    dead_low: RST_DEAD_LOW, dead_high: RST_DEAD_HIGH,
                    full_forward: RST_FULL_FORWARD, full_reverse: RST_FULL_REVERSE,
                    center: RST_CENTER};
      stamp[0]     = '0;
      stamp[1]     = '0;
      dac_hold     = DAC_IDLE;
      front_hold   = RST_BRAKE_FRONT;
      rear_hold    = RST_BRAKE_REAR;
      steer_a_hold = RST_STEER;
      steer_b_hold = RST_STEER;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_VALID_MIN:    regs.valid_min    = cfg_data;
          REG_VALID_MAX:    regs.valid_max    = cfg_data;
          REG_DEAD_LOW:     regs.dead_low     = cfg_data;
          REG_DEAD_HIGH:    regs.dead_high    = cfg_data;
          REG_FULL_FORWARD: regs.full_forward = cfg_data;
          REG_FULL_REVERSE: regs.full_reverse = cfg_data;
          REG_CENTER:       regs.center       = cfg_data;
          default: ;
        endcase
      end
      // retire the oldest result before predicting: no edge answers in its own cycle
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction: %p", result);
        end else begin
          want = pending_results.pop_front();
          done_count++;
          diffs = field_diffs(result, want);
          if (diffs != "") begin
            fail_count++;
            if (fail_count <= 10) $display("result transaction %0d mismatch:%s", done_count, diffs);
          end
        end
      end
      if (push && !full) decode_edge(item);
    end
    mismatches  <= fail_count;
    outstanding <= pending_results.size();
    checked     <= done_count;
  end

endmodule

FILE: bench/rc_pulse_to_actuator_mapper_unit_test.sv
// Testbench top for the RC pulse to actuator mapper: clock, reset, edge stimulus,
// register settings and result draining. Uses rcpam_pkg, the unit and the checker.
module rc_pulse_to_actuator_mapper_unit_test;
  import rcpam_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 600;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  in_t               item;
  logic              empty;
  logic              pop;
  res_t              result;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [REG_W-1:0]  cfg_data;

  int                fail_total;
  int                waiting;
  int                checked_total;
  int                sent = 0;
  int                settings_run = 0;
  bit                steady = 1'b0;
  logic              hold_off_req = 1'b0;
  bit                armed [2] = '{1'b0, 1'b0};
  logic [TICK_W-1:0] rise_at [2];

  rc_pulse_to_actuator_mapper_unit DUT (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result, .cfg_we, .cfg_index, .cfg_data
  );

  rc_pulse_to_actuator_mapper_checker pulse_check (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result, .cfg_we, .cfg_index, .cfg_data,
    .mismatches(fail_total), .outstanding(waiting), .checked(checked_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #6_400_000;
    $display("Verification failed");
    $finish;
  end

  // Result side: random pops (pop held high in steady mode), one long hold-off once a result waits.
  initial begin : sink
    int stall_left;
    bit stalled;
    stall_left = 0;
    stalled    = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !stalled && !empty) begin
        stalled    = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (steady) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic offer(input in_t ev);
    while (!steady && $urandom_range(99) < 30) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= ev;
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic pulse(input logic ch, input logic [TICK_W-1:0] rise,
                       input logic [TICK_W-1:0] ticks);
    offer(in_t'{channel: ch, level: 1'b1, timer_value: rise});
    offer(in_t'{channel: ch, level: 1'b0, timer_value: rise - ticks});
  endtask

  // Wait out every expected result, then the tail of any rising edge in flight.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    logic [IDX_W-1:0] idx [7];
    logic [REG_W-1:0] val [7];
    idx = '{REG_VALID_MIN, REG_VALID_MAX, REG_DEAD_LOW, REG_DEAD_HIGH,
            REG_FULL_FORWARD, REG_FULL_REVERSE, REG_CENTER};
    val = '{c.valid_min, c.valid_max, c.dead_low, c.dead_high,
            c.full_forward, c.full_reverse, c.center};
    foreach (idx[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Ordered window: valid_min < full_forward < dead_low <= center <= dead_high < ...
  function automatic cfg_t plausible_settings();
    cfg_t c;
    c.valid_min    = 16'($urandom_range(14000, 8000));
    c.full_forward = c.valid_min + 16'($urandom_range(4000, 500));
    c.dead_low     = c.full_forward + 16'($urandom_range(8000, 1));
    c.center       = c.dead_low + 16'($urandom_range(1500, 0));
    c.dead_high    = c.center + 16'($urandom_range(1500, 0));
    c.full_reverse = c.dead_high + 16'($urandom_range(8000, 1));
    c.valid_max    = c.full_reverse + 16'($urandom_range(5000, 0));
    return c;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.valid_min    = 16'($urandom_range(65535));
    c.valid_max    = 16'($urandom_range(65535));
    c.dead_low     = 16'($urandom_range(65535));
    c.dead_high    = 16'($urandom_range(65535));
    c.full_forward = 16'($urandom_range(65535));
    c.full_reverse = 16'($urandom_range(65535));
    c.center       = 16'($urandom_range(65535));
    return c;
  endfunction

  // Mostly rise/fall pairs per channel, widths often near the register marks,
  // interleaved across channels, plus stray edges that break the pairing.
  task automatic run_phase(input cfg_t c, input int count);
    in_t ev;
    int  marks [7];
    int  w;
    int  r;
    drain();
    load_settings(c);
    settings_run++;
    marks = '{int'(c.valid_min), int'(c.valid_max), int'(c.dead_low), int'(c.dead_high),
              int'(c.full_forward), int'(c.full_reverse), int'(c.center)};
    repeat (count) begin
      ev.channel = 1'($urandom_range(1));
      if ($urandom_range(99) < 12) begin
        ev.level       = 1'($urandom_range(1));
        ev.timer_value = 24'($urandom());
      end else if (!armed[ev.channel]) begin
        ev.level       = 1'b1;
        ev.timer_value = 24'($urandom());
      end else begin
        r = int'($urandom_range(99));
        if (r < 60) begin
          w = marks[$urandom_range(6)];
          if ($urandom_range(1)) w = w + int'($urandom_range(6)) - 3;
          else w = w + int'($urandom_range(4000)) - 2000;
        end else if (r < 90) begin
          w = int'($urandom_range(70000));
        end else begin
          w = int'($urandom());
        end
        ev.level       = 1'b0;
        ev.timer_value = rise_at[ev.channel] - w[TICK_W-1:0];
      end
      armed[ev.channel] = ev.level;
      if (ev.level) rise_at[ev.channel] = ev.timer_value;
      offer(ev);
    end
  endtask

  initial begin : stimulus
    cfg_t defaults;
    push      <= 1'b0;
    item      <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_VALID_MIN;
    cfg_data  <= '0;
    rst       <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    defaults = cfg_t'{valid_min: RST_VALID_MIN, valid_max: RST_VALID_MAX,
                      dead_low: RST_DEAD_LOW, dead_high: RST_DEAD_HIGH,
                      full_forward: RST_FULL_FORWARD, full_reverse: RST_FULL_REVERSE,
                      center: RST_CENTER};
    load_settings(defaults);
    settings_run++;

    // falling edges with no rising edge use the cleared timestamps
    offer(in_t'{channel: 1'b0, level: 1'b0, timer_value: 24'h000000});
    offer(in_t'{channel: 1'b1, level: 1'b0, timer_value: 24'hFFFFFF});
    pulse(1'b0, 24'hFFFFFF, 24'd16000);
    pulse(1'b0, 24'h000005, 24'd32000);
    pulse(1'b0, 24'hA5A5A5, 24'd24000);
    pulse(1'b1, 24'h000000, 24'd16000);
    pulse(1'b1, 24'hFFFFFF, 24'd32000);
    pulse(1'b1, 24'h5A5A5A, 24'd24000);
    pulse(1'b0, 24'h123456, 24'd12800);
    pulse(1'b1, 24'h000010, 24'd35200);
    pulse(1'b0, 24'hFFFFFF, 24'd35199);
    pulse(1'b0, 24'h000000, 24'd12801);
    pulse(1'b1, 24'h800000, 24'd24800);

    run_phase(defaults, 100);
    run_phase(plausible_settings(), 100);
    hold_off_req <= 1'b1;
    run_phase(plausible_settings(), 100);
    run_phase('0, 100);
    run_phase('1, 100);
    // misordered deadband, zero throttle scale, negative brake scale, flat steering
    run_phase(cfg_t'{valid_min: 16'd0, valid_max: 16'hFFFF, dead_low: 16'd30000,
                     dead_high: 16'd20000, full_forward: 16'd30000,
                     full_reverse: 16'd10000, center: 16'd10000}, 100);
    // one-tick scales drive the DAC and brakes into saturation
    run_phase(cfg_t'{valid_min: 16'd0, valid_max: 16'hFFFF, dead_low: 16'd2000,
                     dead_high: 16'd63000, full_forward: 16'd1999,
                     full_reverse: 16'd63001, center: 16'd40000}, 100);
    // steering scale running backward
    run_phase(cfg_t'{valid_min: 16'd1000, valid_max: 16'd60000, dead_low: 16'd30000,
                     dead_high: 16'd31000, full_forward: 16'd0,
                     full_reverse: 16'd5000, center: 16'd50000}, 100);
    steady = 1'b1;
    run_phase(plausible_settings(), 100);
    steady = 1'b0;
    run_phase(random_settings(), 100);
    run_phase(random_settings(), 100);
    run_phase(plausible_settings(), 100);
    drain();

    $display("Sent %0d edge events under %0d register settings; %0d pulse results checked.",
             sent, settings_run, checked_total);
    if (fail_total == 0 && waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rcpam_pkg.sv
rtl/rcpam_fifo.sv
rtl/rcpam_front.sv
rtl/rcpam_div.sv
rtl/rcpam_back.sv
rtl/rc_pulse_to_actuator_mapper_unit.sv
bench/rc_pulse_to_actuator_mapper_checker.sv
bench/rc_pulse_to_actuator_mapper_unit_test.sv
